FILE: hdl/pdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared types and constants of the pcm decimator / requantizer.
// ----------------------------------------------------------------------------
package pdr_pkg;

  localparam int unsigned SampleW         = 16;
  localparam int unsigned RatioW          = 5;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned CfgDataW        = 5;
  localparam int unsigned MaxDecimDefault = 16;
  localparam int unsigned QueueDepth      = 2;
  // largest ratio the 5-bit register can ever ask for
  localparam int unsigned RatioLimit      = 31;

  localparam logic [SampleW-1:0] MidCode16 = 16'h8000;
  localparam logic [7:0]         MidCode8  = 8'h80;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_WIDE    = 3'd0,
    CFG_SRC_TWO_CH  = 3'd1,
    CFG_DST_WIDE    = 3'd2,
    CFG_DST_TWO_CH  = 3'd3,
    CFG_DECIM_RATIO = 3'd4
  } cfg_idx_e;

  // depth/channel setup that travels with each finished group
  typedef struct packed {
    logic src_wide;
    logic dst_wide;
    logic dst_two_ch;
  } conv_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

endpackage

FILE: hdl/pdr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_in_if
// Input frame channel: valid/ready with left and right raw codes.
// ----------------------------------------------------------------------------
interface pdr_in_if;
  logic                         valid;
  logic                         ready;
  logic [pdr_pkg::SampleW-1:0]  sample_left;
  logic [pdr_pkg::SampleW-1:0]  sample_right;

  modport source (output valid, output sample_left, output sample_right, input ready);
  modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

FILE: hdl/pdr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_out_if
// Output frame channel: valid/ready with left and right result codes.
// ----------------------------------------------------------------------------
interface pdr_out_if;
  logic                         valid;
  logic                         ready;
  logic [pdr_pkg::SampleW-1:0]  out_left;
  logic [pdr_pkg::SampleW-1:0]  out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

FILE: hdl/pdr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_fifo
// Small register queue between the accumulator and the divider.
// ----------------------------------------------------------------------------
module pdr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = pdr_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hdl/pdr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_front
// Config registers, sample decode and per-channel group accumulation.
// ----------------------------------------------------------------------------
module pdr_front #(
  parameter int unsigned MaxDecim = pdr_pkg::MaxDecimDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pdr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pdr_pkg::CfgDataW-1:0]  cfg_data_i,
  pdr_in_if.sink                        in_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [pdr_pkg::RatioW + $bits(pdr_pkg::conv_t)
                + 2 * (pdr_pkg::SampleW + 1
                + $clog2((MaxDecim < pdr_pkg::RatioLimit) ? MaxDecim
                         : pdr_pkg::RatioLimit)) - 1:0] push_data_o
);

  localparam int unsigned RatioW = pdr_pkg::RatioW;
  localparam int unsigned SampleW = pdr_pkg::SampleW;
  localparam int unsigned EffMax =
    (MaxDecim < pdr_pkg::RatioLimit) ? MaxDecim : pdr_pkg::RatioLimit;
  localparam int unsigned SumW = SampleW + 1 + $clog2(EffMax);
  localparam int unsigned CntW = $clog2(EffMax + 1);

  logic                 src_wide_q, src_two_ch_q, dst_wide_q, dst_two_ch_q;
  logic [RatioW-1:0]    ratio_q;
  logic [SumW-1:0]      sum_l_q, sum_l_d, sum_r_q, sum_r_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [SumW-1:0]      dec_l, dec_r, sum_l_new, sum_r_new;
  logic [RatioW-1:0]    eff_ratio, cnt_inc;
  logic                 group_done, accept;
  pdr_pkg::conv_t       conv;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_wide_q   <= 1'b1;
      src_two_ch_q <= 1'b1;
      dst_wide_q   <= 1'b1;
      dst_two_ch_q <= 1'b1;
      ratio_q      <= RatioW'(1);
    end else if (cfg_we_i) begin
      case (pdr_pkg::cfg_idx_e'(cfg_idx_i))
        pdr_pkg::CFG_SRC_WIDE:    src_wide_q   <= cfg_data_i[0];
        pdr_pkg::CFG_SRC_TWO_CH:  src_two_ch_q <= cfg_data_i[0];
        pdr_pkg::CFG_DST_WIDE:    dst_wide_q   <= cfg_data_i[0];
        pdr_pkg::CFG_DST_TWO_CH:  dst_two_ch_q <= cfg_data_i[0];
        pdr_pkg::CFG_DECIM_RATIO: ratio_q      <= cfg_data_i[RatioW-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the limit acts as the limit
  always_comb begin
    if (ratio_q == '0) begin
      eff_ratio = RatioW'(1);
    end else if (32'(ratio_q) > EffMax) begin
      eff_ratio = RatioW'(EffMax);
    end else begin
      eff_ratio = ratio_q;
    end
  end

  always_comb begin
    if (src_wide_q) begin
      dec_l = {{(SumW - SampleW){in_i.sample_left[SampleW-1]}}, in_i.sample_left};
      dec_r = {{(SumW - SampleW){in_i.sample_right[SampleW-1]}}, in_i.sample_right};
    end else begin
      dec_l = {{(SumW - 8){1'b0}}, in_i.sample_left[7:0]};
      dec_r = {{(SumW - 8){1'b0}}, in_i.sample_right[7:0]};
    end
  end

  assign sum_l_new  = sum_l_q + dec_l;
  // mono source leaves the right sum alone
  assign sum_r_new  = src_two_ch_q ? (sum_r_q + dec_r) : sum_r_q;
  assign cnt_inc    = RatioW'(cnt_q) + 1'b1;
  assign group_done = (cnt_inc >= eff_ratio);

  assign in_i.ready   = push_ready_i;
  assign accept       = in_i.valid && push_ready_i;
  assign push_valid_o = in_i.valid && group_done;

  assign conv.src_wide   = src_wide_q;
  assign conv.dst_wide   = dst_wide_q;
  assign conv.dst_two_ch = dst_two_ch_q;
  assign push_data_o     = {eff_ratio, conv, sum_r_new, sum_l_new};

  always_comb begin
    sum_l_d = sum_l_q;
    sum_r_d = sum_r_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (group_done) begin
        sum_l_d = '0;
        sum_r_d = '0;
        cnt_d   = '0;
      end else begin
        sum_l_d = sum_l_new;
        sum_r_d = sum_r_new;
        cnt_d   = CntW'(cnt_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_l_q <= '0;
      sum_r_q <= '0;
      cnt_q   <= '0;
    end else begin
      sum_l_q <= sum_l_d;
      sum_r_q <= sum_r_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hdl/pdr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_back
// Bit-serial divide of both group sums, depth conversion, output register.
// ----------------------------------------------------------------------------
module pdr_back #(
  parameter int unsigned MaxDecim = pdr_pkg::MaxDecimDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  output logic         pop_ready_o,
  input  logic [pdr_pkg::RatioW + $bits(pdr_pkg::conv_t)
                + 2 * (pdr_pkg::SampleW + 1
                + $clog2((MaxDecim < pdr_pkg::RatioLimit) ? MaxDecim
                         : pdr_pkg::RatioLimit)) - 1:0] pop_data_i,
  pdr_out_if.source    out_o
);

  localparam int unsigned RatioW = pdr_pkg::RatioW;
  localparam int unsigned SampleW = pdr_pkg::SampleW;
  localparam int unsigned ConvW = $bits(pdr_pkg::conv_t);
  localparam int unsigned EffMax =
    (MaxDecim < pdr_pkg::RatioLimit) ? MaxDecim : pdr_pkg::RatioLimit;
  localparam int unsigned SumW = SampleW + 1 + $clog2(EffMax);
  localparam int unsigned StepW = $clog2(SumW);

  pdr_pkg::div_state_e  state_q, state_d;
  logic [SumW-1:0]      quo_l_q, quo_r_q;
  logic [RatioW-1:0]    rem_l_q, rem_r_q, div_q;
  logic                 neg_l_q, neg_r_q;
  pdr_pkg::conv_t       conv_q;
  logic [StepW-1:0]     cnt_q;
  logic                 out_valid_q;
  logic [SampleW-1:0]   out_left_q, out_right_q;

  logic                 load, step, emit;
  logic [SumW-1:0]      in_sum_l, in_sum_r;
  logic [RatioW+SumW-1:0] nxt_l, nxt_r;
  logic [SampleW-1:0]   res_l, res_r;

  assign in_sum_l = pop_data_i[SumW-1:0];
  assign in_sum_r = pop_data_i[2*SumW-1:SumW];

  // one restoring step: returns {remainder, quotient}
  function automatic logic [RatioW+SumW-1:0] div_step(
    input logic [RatioW-1:0] rem,
    input logic [SumW-1:0]   quo,
    input logic [RatioW-1:0] dvs
  );
    logic [RatioW:0]   rem_sh;
    logic [RatioW-1:0] rem_n;
    logic              qbit;
    rem_sh = {rem, quo[SumW-1]};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_n = RatioW'(rem_sh - {1'b0, dvs});
      qbit  = 1'b1;
    end else begin
      rem_n = rem_sh[RatioW-1:0];
      qbit  = 1'b0;
    end
    return {rem_n, quo[SumW-2:0], qbit};
  endfunction

  // restore sign, then requantize the low 16 bits of the average
  function automatic logic [SampleW-1:0] convert(
    input logic [SumW-1:0] quo,
    input logic            neg,
    input pdr_pkg::conv_t  cv
  );
    logic [SampleW-1:0] avg;
    logic [SampleW-1:0] biased;
    logic [SampleW-1:0] res;
    avg    = neg ? (~quo[SampleW-1:0] + 1'b1) : quo[SampleW-1:0];
    biased = avg + pdr_pkg::MidCode16;
    if (cv.src_wide && !cv.dst_wide) begin
      res = {8'h00, biased[SampleW-1:8]};
    end else if (!cv.src_wide && cv.dst_wide) begin
      res = {avg[7:0] ^ pdr_pkg::MidCode8, 8'h00};
    end else if (cv.dst_wide) begin
      res = avg;
    end else begin
      res = {8'h00, avg[7:0]};
    end
    return res;
  endfunction

  assign nxt_l = div_step(rem_l_q, quo_l_q, div_q);
  assign nxt_r = div_step(rem_r_q, quo_r_q, div_q);
  assign res_l = convert(quo_l_q, neg_l_q, conv_q);
  assign res_r = conv_q.dst_two_ch ? convert(quo_r_q, neg_r_q, conv_q) : '0;

  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    load        = 1'b0;
    step        = 1'b0;
    emit        = 1'b0;
    case (state_q)
      pdr_pkg::DIV_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          load    = 1'b1;
          state_d = pdr_pkg::DIV_RUN;
        end
      end
      pdr_pkg::DIV_RUN: begin
        step = 1'b1;
        if (cnt_q == '0) begin
          state_d = pdr_pkg::DIV_DONE;
        end
      end
      pdr_pkg::DIV_DONE: begin
        // output slot free or being drained this cycle
        if (!out_valid_q || out_o.ready) begin
          emit    = 1'b1;
          state_d = pdr_pkg::DIV_IDLE;
        end
      end
      default: state_d = pdr_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdr_pkg::DIV_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_l_q <= in_sum_l[SumW-1];
      neg_r_q <= in_sum_r[SumW-1];
      quo_l_q <= in_sum_l[SumW-1] ? (~in_sum_l + 1'b1) : in_sum_l;
      quo_r_q <= in_sum_r[SumW-1] ? (~in_sum_r + 1'b1) : in_sum_r;
      rem_l_q <= '0;
      rem_r_q <= '0;
      conv_q  <= pop_data_i[2*SumW +: ConvW];
      div_q   <= pop_data_i[2*SumW+ConvW +: RatioW];
      cnt_q   <= StepW'(SumW - 1);
    end else if (step) begin
      {rem_l_q, quo_l_q} <= nxt_l;
      {rem_r_q, quo_r_q} <= nxt_r;
      cnt_q <= cnt_q - 1'b1;
    end
    if (emit) begin
      out_left_q  <= res_l;
      out_right_q <= res_r;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;

endmodule

FILE: hdl/pcm_decimate_and_requantize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_decimate_and_requantize
// Boxcar decimator of pcm frames with 8/16-bit depth conversion.
// Input frames are taken one per cycle while the two-entry group queue has room.
// A completed group passes through the queue to the bit-serial divider, which
// works out one quotient bit a cycle for both sums, then goes to the output register.
// The divider takes a new group only after it has emitted the previous one.
// Reset clears sums, frame count, queue and output valid; registers go to their
// defaults (16-bit stereo both sides, ratio 1).
// ----------------------------------------------------------------------------
module pcm_decimate_and_requantize #(
  parameter int unsigned MaxDecim = pdr_pkg::MaxDecimDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pdr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pdr_pkg::CfgDataW-1:0]  cfg_data_i,
  pdr_in_if.sink                        in_i,
  pdr_out_if.source                     out_o
);

  localparam int unsigned EffMax =
    (MaxDecim < pdr_pkg::RatioLimit) ? MaxDecim : pdr_pkg::RatioLimit;
  localparam int unsigned SumW = pdr_pkg::SampleW + 1 + $clog2(EffMax);
  localparam int unsigned JobW = pdr_pkg::RatioW + $bits(pdr_pkg::conv_t) + 2 * SumW;

  logic            push_valid, push_ready, pop_valid, pop_ready;
  logic [JobW-1:0] push_data, pop_data;

  pdr_front #(
    .MaxDecim (MaxDecim)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pdr_fifo #(
    .Width (JobW),
    .Depth (pdr_pkg::QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pdr_back #(
    .MaxDecim (MaxDecim)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule
